@@ sv/bsa_pkg.sv @@
// Package for the bitmap slab allocator: field widths, status and mode codes,
// the beat types of both channels and the controller/datapath command structs.
// No dependencies.
`default_nettype none

package bsa_pkg;

	localparam int MODE_W = 2;
	localparam int SZ_W   = 13;
	localparam int CID_W  = 10;
	localparam int ADDR_W = 23;
	localparam int ST_W   = 3;

	localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;

	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_NULL      = 3'd1;
	localparam logic [ST_W-1:0] ST_NONE_LEFT = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
	localparam logic [ST_W-1:0] ST_BAD_FREE  = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SZ_W-1:0]   obj_bytes;
		logic [CID_W-1:0]  cache_id;
		logic              null_ref;
		logic [ADDR_W-1:0] free_address;
	} req_beat_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [CID_W-1:0]  new_cache_id;
		logic [ADDR_W-1:0] object_address;
	} rsp_beat_t;

	typedef struct packed {
		logic            clr_we;
		logic            ld_item;
		logic            create_wr;
		logic            res_set;
		logic [ST_W-1:0] res_st;
		logic            fetch;
		logic            slot;
		logic            mul;
		logic            check;
		logic            div_init;
		logic            div_step;
		logic            alloc_wr;
		logic            free_wr;
		logic            emit;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              clr_last;
		logic              none_left;
		logic              null_hit;
		logic              map_empty;
		logic              free_bad;
		logic              div_last;
		logic              out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ sv/bsa_req_if.sv @@
// Request channel of the slab allocator: valid, ready and one request beat.
// Depends on bsa_pkg.
`default_nettype none

interface bsa_req_if
	import bsa_pkg::*;
();
	logic      valid;
	logic      ready;
	req_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/bsa_rsp_if.sv @@
// Response channel of the slab allocator: valid, ready and one response beat.
// Depends on bsa_pkg.
`default_nettype none

interface bsa_rsp_if
	import bsa_pkg::*;
();
	logic      valid;
	logic      ready;
	rsp_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/bsa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module bsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ sv/bsa_datapath.sv @@
// Datapath of the slab allocator: free-map and size memories, cache counter,
// slot encoder, address multiplier, bit-serial slot divider and output register.
// Depends on bsa_pkg and bsa_ram.
`default_nettype none

module bsa_datapath
	import bsa_pkg::*;
#(
	parameter int NUM_CACHES = 1024,
	parameter int PAGE_BYTES = 4096,
	parameter int SLOTS      = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire cmd_t  cmd,
	output sts_t       sts,
	input  wire req_beat_t req_data,
	input  wire        rsp_ready,
	output logic       rsp_valid,
	output rsp_beat_t  rsp_data
);

	localparam int AW     = $clog2(NUM_CACHES);
	localparam int CU_W   = $clog2(NUM_CACHES + 1);
	localparam int KW     = CID_W + CU_W;
	localparam int QW     = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(QW + 1);
	localparam int LW     = SZ_W + QW;
	localparam int CMP_W  = (LW > ADDR_W) ? LW : ADDR_W;
	localparam int BW     = CID_W + $clog2(PAGE_BYTES) + 1;
	localparam int WW     = (BW > ADDR_W) ? BW : ADDR_W;
	localparam int PROD_W = SZ_W + QW;

	req_beat_t          item_q;
	logic [CU_W-1:0]    used_q;
	logic [AW-1:0]      clr_q;
	logic [SLOTS-1:0]   map_q;
	logic [SZ_W-1:0]    size_q;
	logic [WW-1:0]      base_q;
	logic [QW-1:0]      slot_q;
	logic [PROD_W-1:0]  prod_q;
	logic [CMP_W-1:0]   off_q;
	logic [CMP_W-1:0]   lim_q;
	logic               bad_q;
	logic [CMP_W-1:0]   rem_q;
	logic [CMP_W-1:0]   dsh_q;
	logic [QW-1:0]      quo_q;
	logic [CNT_W-1:0]   cnt_q;
	rsp_beat_t          res_q;
	rsp_beat_t          out_q;
	logic               out_valid_q;

	logic [AW-1:0]      cid_idx;
	logic [SLOTS-1:0]   map_rd;
	logic [SZ_W-1:0]    size_rd;
	logic               map_we;
	logic [AW-1:0]      map_waddr;
	logic [SLOTS-1:0]   map_wdata;
	logic               size_we;
	logic [AW-1:0]      size_waddr;
	logic [SZ_W-1:0]    size_wdata;
	logic [SLOTS-1:0]   low_bit;
	logic [QW-1:0]      low_idx;
	logic [WW-1:0]      faddr_w;
	logic [WW-1:0]      alloc_addr;

	assign cid_idx = AW'(item_q.cache_id);

	always_comb begin
		map_we     = cmd.clr_we | cmd.alloc_wr | cmd.free_wr;
		map_waddr  = cmd.clr_we ? clr_q : cid_idx;
		size_we    = cmd.clr_we | cmd.create_wr;
		size_waddr = cmd.clr_we ? clr_q : AW'(used_q);
		size_wdata = cmd.clr_we ? '0 : item_q.obj_bytes;
		if (cmd.clr_we) begin
			map_wdata = '1;
		end else if (cmd.free_wr) begin
			map_wdata = map_q | (SLOTS'(1) << quo_q);
		end else begin
			map_wdata = map_q;
		end
	end

	bsa_ram #(.WIDTH(SLOTS), .DEPTH(NUM_CACHES)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (cid_idx),
		.rdata (map_rd)
	);

	bsa_ram #(.WIDTH(SZ_W), .DEPTH(NUM_CACHES)) u_size_ram (
		.clk   (clk),
		.we    (size_we),
		.waddr (size_waddr),
		.wdata (size_wdata),
		.raddr (cid_idx),
		.rdata (size_rd)
	);

	always_comb begin
		low_bit = map_q & (~map_q + SLOTS'(1));
		low_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (low_bit[i]) begin
				low_idx = low_idx | QW'(i);
			end
		end
	end

	assign faddr_w    = WW'(item_q.free_address);
	assign alloc_addr = base_q + WW'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_we) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.create_wr) begin
				used_q <= used_q + CU_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			item_q <= req_data;
		end
		if (cmd.fetch) begin
			map_q  <= map_rd;
			size_q <= size_rd;
			base_q <= WW'(item_q.cache_id) * WW'(PAGE_BYTES);
		end
		if (cmd.slot) begin
			slot_q <= low_idx;
			map_q  <= map_q & ~low_bit;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(slot_q) * PROD_W'(size_q);
		end
		if (cmd.check) begin
			off_q <= CMP_W'(faddr_w - base_q);
			lim_q <= CMP_W'(size_q) * CMP_W'(SLOTS);
			bad_q <= (size_q == '0) || (faddr_w < base_q);
		end
		if (cmd.div_init) begin
			rem_q <= off_q;
			dsh_q <= CMP_W'(size_q) << (QW - 1);
			quo_q <= '0;
			cnt_q <= CNT_W'(QW - 1);
		end
		if (cmd.div_step) begin
			if (rem_q >= dsh_q) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QW-2:0], rem_q >= dsh_q};
			dsh_q <= dsh_q >> 1;
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.res_set) begin
			res_q.status         <= cmd.res_st;
			res_q.new_cache_id   <= '0;
			res_q.object_address <= '0;
		end
		if (cmd.create_wr) begin
			res_q.status         <= ST_OK;
			res_q.new_cache_id   <= CID_W'(used_q);
			res_q.object_address <= '0;
		end
		if (cmd.alloc_wr) begin
			res_q.status         <= ST_OK;
			res_q.new_cache_id   <= '0;
			res_q.object_address <= alloc_addr[ADDR_W-1:0];
		end
		if (cmd.free_wr) begin
			res_q.status         <= ST_OK;
			res_q.new_cache_id   <= '0;
			res_q.object_address <= '0;
		end
		if (cmd.emit) begin
			out_q <= res_q;
		end
	end

	always_comb begin
		sts.mode      = item_q.mode;
		sts.clr_last  = (clr_q == AW'(NUM_CACHES - 1));
		sts.none_left = (used_q >= CU_W'(NUM_CACHES));
		sts.null_hit  = item_q.null_ref || (KW'(item_q.cache_id) >= KW'(NUM_CACHES));
		sts.map_empty = (map_q == '0);
		sts.free_bad  = bad_q || (off_q >= lim_q);
		sts.div_last  = (cnt_q == '0);
		sts.out_free  = !out_valid_q || rsp_ready;
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule

`default_nettype wire

@@ sv/bsa_ctrl.sv @@
// Controller of the slab allocator: sequences the clearing pass after reset
// and the steps of create, alloc and free. Depends on bsa_pkg.
`default_nettype none

module bsa_ctrl
	import bsa_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_ready,
	input  wire sts_t sts,
	output cmd_t cmd
);

	localparam int SW = 4;
	localparam logic [SW-1:0] S_CLEAR  = 4'd0;
	localparam logic [SW-1:0] S_IDLE   = 4'd1;
	localparam logic [SW-1:0] S_DECODE = 4'd2;
	localparam logic [SW-1:0] S_FETCH  = 4'd3;
	localparam logic [SW-1:0] S_SLOT   = 4'd4;
	localparam logic [SW-1:0] S_MUL    = 4'd5;
	localparam logic [SW-1:0] S_ADDR   = 4'd6;
	localparam logic [SW-1:0] S_CHECK  = 4'd7;
	localparam logic [SW-1:0] S_TEST   = 4'd8;
	localparam logic [SW-1:0] S_DIV    = 4'd9;
	localparam logic [SW-1:0] S_SETBIT = 4'd10;
	localparam logic [SW-1:0] S_DONE   = 4'd11;

	logic [SW-1:0] state_q;
	logic [SW-1:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.ld_item = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				unique case (sts.mode)
					MODE_CREATE: begin
						if (sts.none_left) begin
							cmd.res_set = 1'b1;
							cmd.res_st  = ST_NONE_LEFT;
						end else begin
							cmd.create_wr = 1'b1;
						end
					end
					MODE_ALLOC, MODE_FREE: begin
						if (sts.null_hit) begin
							cmd.res_set = 1'b1;
							cmd.res_st  = ST_NULL;
						end else begin
							state_d = S_FETCH;
						end
					end
					default: begin
						cmd.res_set = 1'b1;
						cmd.res_st  = ST_OK;
					end
				endcase
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = (sts.mode == MODE_ALLOC) ? S_SLOT : S_CHECK;
			end
			S_SLOT: begin
				if (sts.map_empty) begin
					cmd.res_set = 1'b1;
					cmd.res_st  = ST_FULL;
					state_d     = S_DONE;
				end else begin
					cmd.slot = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADDR;
			end
			S_ADDR: begin
				cmd.alloc_wr = 1'b1;
				state_d      = S_DONE;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_TEST;
			end
			S_TEST: begin
				if (sts.free_bad) begin
					cmd.res_set = 1'b1;
					cmd.res_st  = ST_BAD_FREE;
					state_d     = S_DONE;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_SETBIT;
				end
			end
			S_SETBIT: begin
				cmd.free_wr = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/bitmap_slab_allocator_unit.sv @@
// Top level of the bitmap slab allocator: joins the controller and the datapath
// to the request and response channels. Depends on bsa_pkg, bsa_req_if,
// bsa_rsp_if, bsa_ctrl and bsa_datapath.
`default_nettype none

// The block serves one request at a time. After reset it runs a clearing pass
// that marks every slot free and every size zero; req.ready stays low until it
// ends. A create, a null reference or mode 3 is answered from decode. An alloc
// takes the lowest free slot and adds slot times object size to the cache base,
// or reports a full cache. A free checks the address range, refuses a bad free,
// and else runs the bit-serial divider that turns the offset into a slot number
// and marks that slot free. A finished response waits for as long as the
// previous beat sits unaccepted in the output register. The next request is
// taken in the cycle after the response is loaded.
module bitmap_slab_allocator_unit
	import bsa_pkg::*;
#(
	parameter int NUM_CACHES = 1024,
	parameter int PAGE_BYTES = 4096,
	parameter int SLOTS      = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	bsa_req_if.sink    req,
	bsa_rsp_if.source  rsp
);

	cmd_t      cmd;
	sts_t      sts;
	logic      in_ready;
	logic      rsp_valid;
	rsp_beat_t rsp_data;

	bsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsa_datapath #(
		.NUM_CACHES (NUM_CACHES),
		.PAGE_BYTES (PAGE_BYTES),
		.SLOTS      (SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_data  (req.data),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data)
	);

	assign req.ready = in_ready;
	assign rsp.valid = rsp_valid;
	assign rsp.data  = rsp_data;

endmodule

`default_nettype wire

@@ sv/bsa_checker.sv @@
// Port-level checker for the bitmap slab allocator and the bind that attaches
// it to the top level. Depends on bsa_pkg and bitmap_slab_allocator_unit.
`default_nettype none

module bsa_checker
	import bsa_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       req_valid,
	input wire       req_ready,
	input wire       rsp_valid,
	input wire       rsp_ready,
	input wire rsp_beat_t rsp_data
);

	// A stalled response beat keeps its valid and its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response beat changed while stalled");

	// Only one request is in work, so ready drops after every accepted beat.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in work");

	// Status codes stay within the defined set.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_NULL ||
			rsp_data.status == ST_NONE_LEFT || rsp_data.status == ST_FULL ||
			rsp_data.status == ST_BAD_FREE))
		else $error("undefined status code");

	// A failed request returns neither a cache index nor an address.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |->
			rsp_data.new_cache_id == '0 && rsp_data.object_address == '0)
		else $error("failed request carries a result value");

endmodule

bind bitmap_slab_allocator_unit bsa_checker u_bsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
